### sv/pbu_pkg.sv
// Shared constants, request and status codes, divider interface types.
`default_nettype none
package pbu_pkg;

	localparam logic [31:0] ONE_Q31  = 32'h8000_0000;
	localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
	localparam logic [32:0] HALF_Q32 = 33'h0_8000_0000;
	localparam logic [16:0] PROB_ONE = 17'h1_0000;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_ADD    = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [32:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
	} div_rsp_t;

endpackage
`default_nettype wire

### sv/pbu_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module pbu_ram #(
	parameter int W = 32,
	parameter int D = 64
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic                 re,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### sv/pbu_div.sv
// Radix-2 restoring divider, 32 quotient bits, result saturated to one in Q1.31.
`default_nettype none
module pbu_div
	import pbu_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int STEPS = 32;
	localparam int CNT_W = $clog2(STEPS);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic [32:0]      den_q;
	logic [32:0]      rem_q;
	logic [31:0]      lo_q;
	logic [31:0]      quo_q;
	logic [33:0]      r2;
	logic [33:0]      r2_sub;
	logic             ge;
	logic             start_ovf;

	assign r2     = {rem_q, lo_q[31]};
	assign ge     = r2 >= {1'b0, den_q};
	assign r2_sub = r2 - {1'b0, den_q};

	// quotient of 2^32 or more: saturate at once
	assign start_ovf = {1'b0, req.num[63:32]} >= req.den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= (req.start && start_ovf)
				|| (!req.start && busy_q && cnt_q == CNT_W'(STEPS - 1));
			if (req.start) begin
				cnt_q  <= '0;
				busy_q <= !start_ovf;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			ovf_q <= start_ovf;
			rem_q <= {1'b0, req.num[63:32]};
			lo_q  <= req.num[31:0];
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? r2_sub[32:0] : r2[32:0];
			lo_q  <= {lo_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = (ovf_q || quo_q > ONE_Q31) ? ONE_Q31 : quo_q;

endmodule
`default_nettype wire

### sv/poisson_binomial_update.sv
// Poisson-binomial distribution table with trial add/remove and table read-out.
//
// The block holds P(exactly k successes) for k = 0 .. n-1 in Q1.31, one
// entry per word of a single RAM. One input item is a request: clear the
// table to the single certain entry, add a trial of probability
// prob_left*prob_right (Q1.16 factors, clamped at one), or remove such a
// trial. Items are taken one at a time; s_axis_tready is high only while the
// block is idle. Every request is answered with the whole table, one output
// item per entry from index 0, tlast on the top entry, and the same status
// and sum-within-tolerance flag on every item. A request forms p and
// decodes; an add rewrites each entry of the grown table through one
// shared 32x33 multiplier, used twice per entry; a remove rewrites each
// entry of the shrunk table with read, two multiplies, setup, the
// bit-serial divider (32 steps, then the quotient is handed over) and
// write-back; the divider answers at once when the quotient saturates and
// is skipped when the numerator is not positive. A remove then clears the
// old top entry, and the backward form first primes its start. The table
// is then summed and sent one output item at a time, each held until the
// sink is ready. Clear empties the table through per-entry valid flags;
// an entry not yet written reads as one at index 0 and zero elsewhere.
// sum_tolerance is written on the cfg port, which is always ready.
`default_nettype none
module poisson_binomial_update
	import pbu_pkg::*;
#(
	parameter int MAX_TRIALS = 63
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// cfg_data: sum_tolerance [15:0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	// s_axis_tdata: prob_left [16:0], prob_right [33:17], zero [39:34]
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,
	// s_axis_tuser: req_type [1:0]
	input  wire logic [1:0]  s_axis_tuser,
	// m_axis_tdata: entry_index [5:0], entry_value [37:6], zero [39:38]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [39:0] m_axis_tdata,
	// m_axis_tuser: sum_ok [0], status [2:1]
	output logic      [2:0]  m_axis_tuser,
	// m_axis_tlast: last_entry
	output logic             m_axis_tlast
);

	localparam int DEPTH = MAX_TRIALS + 1;
	localparam int IW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int SW    = 32 + CW;

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_FWD = 2'd1;
	localparam logic [1:0] MODE_BWD = 2'd2;

	typedef enum logic [17:0] {
		ST_IDLE = 18'h00001,
		ST_PROB = 18'h00002,
		ST_DISP = 18'h00004,
		ST_PRE  = 18'h00008,
		ST_PRE2 = 18'h00010,
		ST_RD   = 18'h00020,
		ST_MUL  = 18'h00040,
		ST_MUL2 = 18'h00080,
		ST_DSET = 18'h00100,
		ST_DIV  = 18'h00200,
		ST_WR   = 18'h00400,
		ST_ZERO = 18'h00800,
		ST_SUM  = 18'h01000,
		ST_SUML = 18'h02000,
		ST_CHK  = 18'h04000,
		ST_ERD  = 18'h08000,
		ST_ELD  = 18'h10000,
		ST_EWT  = 18'h20000
	} state_t;

	state_t          state_q;
	logic [1:0]      mode_q;
	logic [1:0]      status_q;
	logic [CW-1:0]   n_q;
	logic [IW-1:0]   k_q;
	logic [DEPTH-1:0] valid_q;
	logic [15:0]     tol_q;

	logic [1:0]      req_q;
	logic [16:0]     pl_q;
	logic [16:0]     pr_q;
	logic [32:0]     p_q;
	logic [32:0]     q_q;
	logic [31:0]     cur_q;
	logic [31:0]     lo_q;
	logic [31:0]     prev_q;
	logic [31:0]     res_q;
	logic [64:0]     acc_q;
	logic [64:0]     prod_q;
	logic [63:0]     diff_q;
	logic            zero_q;
	logic [SW-1:0]   sum_q;
	logic            ok_q;
	logic            rvld_s1;
	logic            rzero_s1;
	logic            sum_rd_s1;

	logic [5:0]      out_idx_q;
	logic [31:0]     out_val_q;
	logic            out_last_q;

	logic            ram_we;
	logic [IW-1:0]   ram_waddr;
	logic [31:0]     ram_wdata;
	logic            ram_re;
	logic [IW-1:0]   ram_raddr;
	logic [31:0]     ram_rdata;

	logic [31:0]     mult_a;
	logic [32:0]     mult_b;
	logic [31:0]     rd_val;
	logic [IW-1:0]   n_m1;
	logic [IW-1:0]   k_m1;
	logic [65:0]     add_total;
	logic [33:0]     add_shift;
	logic [31:0]     add_val;
	logic [64:0]     a_num;
	logic [32:0]     den;
	logic [SW-1:0]   sum_gap;
	logic            in_acc;
	logic [16:0]     in_pl;
	logic [16:0]     in_pr;

	div_req_t        div_req;
	div_rsp_t        div_rsp;

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = state_q == ST_IDLE;
	assign cfg_ready     = 1'b1;

	// factors above one clamp to one
	assign in_pl = (s_axis_tdata[16:0] > PROB_ONE) ? PROB_ONE : s_axis_tdata[16:0];
	assign in_pr = (s_axis_tdata[33:17] > PROB_ONE) ? PROB_ONE : s_axis_tdata[33:17];

	// entries never written since the last clear read as the cleared table
	assign rd_val = rvld_s1 ? ram_rdata : (rzero_s1 ? ONE_Q31 : 32'd0);

	assign n_m1 = IW'(n_q - 1'b1);
	assign k_m1 = k_q - 1'b1;

	// add: old[k]*q + old[k-1]*p, round half up, drop 32 fraction bits, saturate
	assign add_total = {1'b0, acc_q} + {1'b0, prod_q} + 66'(HALF_Q32);
	assign add_shift = add_total[65:32];
	assign add_val   = (add_shift > {2'b00, ONE_Q31}) ? ONE_Q31 : add_shift[31:0];

	// remove: numerator old<<32, divisor q going forward, p going backward
	assign a_num = {1'b0, cur_q, 32'd0};
	assign den   = (mode_q == MODE_FWD) ? q_q : p_q;

	assign sum_gap = (sum_q > SW'(ONE_Q31)) ? sum_q - SW'(ONE_Q31) : SW'(ONE_Q31) - sum_q;

	assign div_req.start = (state_q == ST_DSET) && !zero_q;
	assign div_req.num   = diff_q + 64'(den >> 1);
	assign div_req.den   = den;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = k_q;
		ram_we    = 1'b0;
		ram_waddr = k_q;
		ram_wdata = res_q;
		mult_a    = '0;
		mult_b    = '0;
		case (state_q)
			ST_PROB: begin
				mult_a = 32'(pl_q);
				mult_b = 33'(pr_q);
			end
			ST_PRE: begin
				ram_re    = 1'b1;
				ram_raddr = n_m1;
			end
			ST_RD: begin
				ram_re    = (mode_q != MODE_ADD) || (k_q != '0);
				ram_raddr = (mode_q == MODE_FWD) ? k_q : k_m1;
			end
			ST_MUL: begin
				case (mode_q)
					MODE_ADD: begin
						mult_a = cur_q;
						mult_b = q_q;
					end
					MODE_FWD: begin
						mult_a = prev_q;
						mult_b = p_q;
					end
					default: begin
						mult_a = prev_q;
						mult_b = q_q;
					end
				endcase
			end
			ST_MUL2: begin
				mult_a = lo_q;
				mult_b = p_q;
			end
			ST_WR: begin
				ram_we    = 1'b1;
				ram_waddr = (mode_q == MODE_BWD) ? k_m1 : k_q;
				ram_wdata = (mode_q == MODE_ADD) ? add_val : res_q;
			end
			ST_ZERO: begin
				ram_we    = 1'b1;
				ram_waddr = n_m1;
				ram_wdata = '0;
			end
			ST_SUM, ST_ERD: begin
				ram_re = 1'b1;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mode_q        <= MODE_ADD;
			status_q      <= STAT_OK;
			n_q           <= CW'(1);
			k_q           <= '0;
			valid_q       <= '0;
			tol_q         <= 16'd2147;
			m_axis_tvalid <= 1'b0;
			sum_rd_s1     <= 1'b0;
		end else begin
			sum_rd_s1 <= state_q == ST_SUM;
			if (cfg_valid && cfg_ready) begin
				tol_q <= cfg_data;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_PROB;
					end
				end
				ST_PROB: begin
					state_q <= ST_DISP;
				end
				ST_DISP: begin
					case (req_q)
						REQ_CLEAR: begin
							status_q <= STAT_OK;
							k_q      <= '0;
							state_q  <= ST_SUM;
							valid_q  <= '0;
							n_q      <= CW'(1);
						end
						REQ_ADD: begin
							if (n_q == CW'(DEPTH)) begin
								status_q <= STAT_FULL;
								k_q      <= '0;
								state_q  <= ST_SUM;
							end else begin
								status_q <= STAT_OK;
								mode_q   <= MODE_ADD;
								k_q      <= IW'(n_q);
								state_q  <= ST_RD;
							end
						end
						REQ_REMOVE: begin
							k_q <= '0;
							if (n_q == CW'(1)) begin
								status_q <= STAT_EMPTY;
								state_q  <= ST_SUM;
							end else if (prod_q[32:0] < HALF_Q32) begin
								status_q <= STAT_OK;
								mode_q   <= MODE_FWD;
								state_q  <= ST_RD;
							end else begin
								status_q <= STAT_OK;
								mode_q   <= MODE_BWD;
								state_q  <= ST_PRE;
							end
						end
						default: begin
							status_q <= STAT_OK;
							k_q      <= '0;
							state_q  <= ST_SUM;
						end
					endcase
				end
				ST_PRE: begin
					state_q <= ST_PRE2;
				end
				ST_PRE2: begin
					k_q     <= n_m1;
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= (mode_q == MODE_ADD) ? ST_WR : ST_DSET;
				end
				ST_DSET: begin
					state_q <= zero_q ? ST_WR : ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					case (mode_q)
						MODE_ADD: begin
							if (k_q == '0) begin
								n_q     <= n_q + 1'b1;
								state_q <= ST_SUM;
							end else begin
								k_q     <= k_m1;
								state_q <= ST_RD;
							end
						end
						MODE_FWD: begin
							if (k_q == IW'(n_q - CW'(2))) begin
								state_q <= ST_ZERO;
							end else begin
								k_q     <= k_q + 1'b1;
								state_q <= ST_RD;
							end
						end
						default: begin
							if (k_q == IW'(1)) begin
								state_q <= ST_ZERO;
							end else begin
								k_q     <= k_m1;
								state_q <= ST_RD;
							end
						end
					endcase
				end
				ST_ZERO: begin
					n_q     <= n_q - 1'b1;
					k_q     <= '0;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (k_q == n_m1) begin
						state_q <= ST_SUML;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_SUML: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					k_q     <= '0;
					state_q <= ST_ERD;
				end
				ST_ERD: begin
					state_q <= ST_ELD;
				end
				ST_ELD: begin
					m_axis_tvalid <= 1'b1;
					state_q       <= ST_EWT;
				end
				ST_EWT: begin
					if (m_axis_tready) begin
						m_axis_tvalid <= 1'b0;
						if (k_q == n_m1) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_ERD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= 65'(mult_a) * 65'(mult_b);
		if (ram_re) begin
			rvld_s1  <= valid_q[ram_raddr];
			rzero_s1 <= ram_raddr == '0;
		end
		if (sum_rd_s1) begin
			sum_q <= sum_q + SW'(rd_val);
		end
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					req_q <= s_axis_tuser;
					pl_q  <= in_pl;
					pr_q  <= in_pr;
					sum_q <= '0;
				end
			end
			ST_DISP: begin
				p_q    <= prod_q[32:0];
				q_q    <= ONE_Q32 - prod_q[32:0];
				cur_q  <= '0;
				prev_q <= '0;
			end
			ST_PRE2: begin
				cur_q <= rd_val;
			end
			ST_MUL: begin
				case (mode_q)
					MODE_ADD: lo_q  <= (k_q == '0) ? 32'd0 : rd_val;
					MODE_FWD: cur_q <= rd_val;
					default:  lo_q  <= rd_val;
				endcase
			end
			ST_MUL2: begin
				acc_q  <= prod_q;
				zero_q <= prod_q >= a_num;
				diff_q <= a_num[63:0] - prod_q[63:0];
			end
			ST_DSET: begin
				if (zero_q) begin
					res_q <= '0;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					res_q <= div_rsp.quo;
				end
			end
			ST_WR: begin
				prev_q <= res_q;
				if (mode_q != MODE_FWD) begin
					cur_q <= lo_q;
				end
			end
			ST_CHK: begin
				ok_q <= sum_gap < SW'(tol_q);
			end
			ST_ELD: begin
				out_idx_q  <= 6'(k_q);
				out_val_q  <= rd_val;
				out_last_q <= k_q == n_m1;
			end
			default: begin
				ok_q <= ok_q;
			end
		endcase
	end

	assign m_axis_tdata = {2'b00, out_val_q, out_idx_q};
	assign m_axis_tuser = {status_q, ok_q};
	assign m_axis_tlast = out_last_q;

	pbu_ram #(
		.W(32),
		.D(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	pbu_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	a_out_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> state_q == ST_EWT)
		else $error("output valid outside the wait state");

	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		n_q != '0 && n_q <= CW'(DEPTH))
		else $error("table size out of range");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re && ram_waddr == ram_raddr))
		else $error("read and write of the same entry in one cycle");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_PROB)
		else $error("accepted item did not start processing");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EWT && status_q == STAT_FULL) |-> n_q == CW'(DEPTH))
		else $error("full status with room in the table");

endmodule
`default_nettype wire
